/* sv/lru_cache_with_eviction_log_defines.svh */
// Assertion macros for the LRU cache with eviction log.
// Used by the top level; relies on clk and arst_n being in scope.
`ifndef LRU_CACHE_WITH_EVICTION_LOG_DEFINES_SVH
`define LRU_CACHE_WITH_EVICTION_LOG_DEFINES_SVH

// Checks the consequent in the same cycle as the antecedent.
`define LCE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define LCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/lce_pkg.sv */
// Shared constants and types for the LRU cache with eviction log.
// No dependencies.
package lce_pkg;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int OP_W      = 2;
	localparam int ECNT_W    = 4;
	localparam int SIZE_W    = 5;
	localparam int IDX_MAX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_DEPTH = 2'd1;

	localparam logic [CFG_W-1:0] CAPACITY_RESET  = 5'd16;
	localparam logic [CFG_W-1:0] LOG_DEPTH_RESET = 5'd8;

	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_GET   = 2'd1;
	localparam logic [OP_W-1:0] OP_EVICT = 2'd2;
	localparam logic [OP_W-1:0] OP_FIND  = 2'd3;

	typedef enum logic [1:0] {
		AGE_NOP,
		AGE_TOUCH,
		AGE_INSERT,
		AGE_DROP
	} age_op_t;

	typedef struct packed {
		age_op_t              op;
		logic [IDX_MAX_W-1:0] idx;
	} age_cmd_t;
endpackage

/* sv/lce_if.sv */
// Channel interfaces for the LRU cache with eviction log.
// Depends on lce_pkg for field widths.
interface lce_req_if #(parameter int KB = 32, parameter int VB = 32);
	logic                  valid;
	logic                  ready;
	logic [lce_pkg::OP_W-1:0] op;
	logic [KB-1:0]         key;
	logic [VB-1:0]         value;
	modport source (output valid, op, key, value, input ready);
	modport sink (input valid, op, key, value, output ready);
endinterface

interface lce_rsp_if #(parameter int KB = 32, parameter int VB = 32);
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic [VB-1:0]              value_out;
	logic                       reason_out;
	logic                       evicted;
	logic [KB-1:0]              evicted_key;
	logic [lce_pkg::ECNT_W-1:0] evict_count;
	logic [lce_pkg::SIZE_W-1:0] size_out;
	modport source (output valid, hit, value_out, reason_out, evicted, evicted_key,
		evict_count, size_out, input ready);
	modport sink (input valid, hit, value_out, reason_out, evicted, evicted_key,
		evict_count, size_out, output ready);
endinterface

interface lce_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lce_pkg::CFG_IDX_W-1:0] idx;
	logic [lce_pkg::CFG_W-1:0]     data;
	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

/* sv/lce_entry_mem.sv */
// Entry store: key and handle per slot, one write and one registered read port.
// Standalone; no package use.
module lce_entry_mem #(
	parameter int DEPTH = 16,
	parameter int KB    = 32,
	parameter int VB    = 32
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [KB-1:0]                       wr_key,
	input  logic [VB-1:0]                       wr_val,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [KB-1:0]                       rd_key,
	output logic [VB-1:0]                       rd_val
);
	logic [KB+VB-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_key, wr_val};
		end
		{rd_key, rd_val} <= mem[rd_addr];
	end
endmodule

/* sv/lce_age.sv */
// Recency tracker: valid bits, ages and live count of the entry slots.
// Depends on lce_pkg for the command struct.
module lce_age #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lce_pkg::age_cmd_t                   cmd,
	output logic [DEPTH-1:0]                    valid,
	output logic [$clog2(DEPTH+1)-1:0]          live,
	output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] lru_idx,
	output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] free_idx
);
	import lce_pkg::*;
	localparam int IW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [DEPTH-1:0] valid_q;
	logic [IW-1:0]    age_q [DEPTH];
	logic [CW-1:0]    live_q;
	logic [IW-1:0]    ci;
	logic [IW-1:0]    oldest;

	assign ci     = cmd.idx[IW-1:0];
	assign oldest = IW'(live_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q  <= '0;
			for (int j = 0; j < DEPTH; j++) age_q[j] <= '0;
		end else begin
			unique case (cmd.op)
				AGE_TOUCH: begin
					for (int j = 0; j < DEPTH; j++) begin
						if (valid_q[j] && age_q[j] < age_q[ci]) age_q[j] <= age_q[j] + IW'(1);
					end
					age_q[ci] <= '0;
				end
				AGE_INSERT: begin
					for (int j = 0; j < DEPTH; j++) begin
						if (valid_q[j]) age_q[j] <= age_q[j] + IW'(1);
					end
					age_q[ci]   <= '0;
					valid_q[ci] <= 1'b1;
					live_q      <= live_q + CW'(1);
				end
				AGE_DROP: begin
					age_q[ci]   <= '0;
					valid_q[ci] <= 1'b0;
					live_q      <= live_q - CW'(1);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		lru_idx  = '0;
		free_idx = '0;
		for (int j = 0; j < DEPTH; j++) begin
			if (valid_q[j] && age_q[j] == oldest) lru_idx = IW'(j);
		end
		for (int j = DEPTH-1; j >= 0; j--) begin
			if (!valid_q[j]) free_idx = IW'(j);
		end
	end

	assign valid = valid_q;
	assign live  = live_q;
endmodule

/* sv/lce_log.sv */
// Eviction log: ring of key, handle and reason records with a bounded depth.
// Depends on lce_pkg for the configuration width.
module lce_log #(
	parameter int LOG_MAX = 16,
	parameter int KB      = 32,
	parameter int VB      = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lce_pkg::CFG_W-1:0]    depth,
	input  logic                         push_en,
	input  logic [KB-1:0]                push_key,
	input  logic [VB-1:0]                push_val,
	input  logic                         push_reason,
	input  logic [$clog2(LOG_MAX+1)-1:0] rd_n,
	output logic [KB-1:0]                rd_key,
	output logic [VB-1:0]                rd_val,
	output logic                         rd_reason,
	output logic [$clog2(LOG_MAX+1)-1:0] count
);
	import lce_pkg::*;
	localparam int LIW = LOG_MAX > 1 ? $clog2(LOG_MAX) : 1;
	localparam int LCW = $clog2(LOG_MAX+1);
	localparam int SW  = (LIW > LCW ? LIW : LCW) + 1;

	logic [KB+VB:0] mem [LOG_MAX];
	logic [LIW-1:0] head_q;
	logic [LCW-1:0] cnt_q;
	logic [LCW-1:0] effd;
	logic [SW-1:0]  wsum;
	logic [SW-1:0]  rsum;
	logic [SW-1:0]  hnext;
	logic [LIW-1:0] wslot;
	logic [LIW-1:0] raddr;
	logic [LIW-1:0] head_nx;
	logic           do_push;

	assign effd = (32'(depth) > LOG_MAX) ? LCW'(LOG_MAX) : LCW'(depth);
	assign wsum = SW'(head_q) + SW'(cnt_q);
	assign rsum = SW'(head_q) + SW'(rd_n);
	assign hnext = SW'(head_q) + SW'(1);
	assign head_nx = (hnext >= SW'(LOG_MAX)) ? '0 : LIW'(hnext);
	assign raddr = (rsum >= SW'(LOG_MAX)) ? LIW'(rsum - SW'(LOG_MAX)) : LIW'(rsum);
	assign do_push = push_en && (push_val != '0);

	always_comb begin
		if (32'(cnt_q) >= LOG_MAX) wslot = head_q;
		else if (wsum >= SW'(LOG_MAX)) wslot = LIW'(wsum - SW'(LOG_MAX));
		else wslot = LIW'(wsum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else if (do_push) begin
			if (32'(cnt_q) >= LOG_MAX) begin
				head_q <= head_nx;
			end else if ((SW'(cnt_q) + SW'(1)) > SW'(effd)) begin
				head_q <= head_nx;
			end else begin
				cnt_q <= cnt_q + LCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wslot] <= {push_key, push_val, push_reason};
		end
		{rd_key, rd_val, rd_reason} <= mem[raddr];
	end

	assign count = cnt_q;
endmodule

/* sv/lru_cache_with_eviction_log.sv */
// Top level of the LRU cache with eviction log: sequencer and result register.
// Depends on lce_pkg, lce_if, lce_entry_mem, lce_age, lce_log and the defines header.
//
//   port   role     moves
//   req    sink     op, key, value
//   rsp    source   hit, value_out, reason_out, evicted, evicted_key, evict_count, size_out
//   cfg    sink     idx, data (capacity, log_depth)
//
// Put, get and evict-all scan the entry memory one slot a cycle, then decide in S_DEC and
// go to the result register through S_OUT; an insert adds S_INS, a put eviction S_VRD and
// S_VLOG before S_INS, and evict-all on a hit passes S_EALOOP, S_VRD and S_VLOG per removed entry.
// Find scans the log one record a cycle in S_FIND before S_OUT.
// An item with key 0 goes straight to S_OUT; the block returns to idle after every item before the next.
// Reset clears control state at once; no clearing pass is needed.
// A waiting result stalls the block only when the next result is ready.
`include "lru_cache_with_eviction_log_defines.svh"

module lru_cache_with_eviction_log #(
	parameter int CAPACITY_MAX = 16,
	parameter int LOG_MAX      = 16,
	parameter int KEY_BITS     = 32,
	parameter int VALUE_BITS   = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	lce_req_if.sink   req,
	lce_rsp_if.source rsp,
	lce_cfg_if.sink   cfg
);
	import lce_pkg::*;
	localparam int IW  = CAPACITY_MAX > 1 ? $clog2(CAPACITY_MAX) : 1;
	localparam int CW  = $clog2(CAPACITY_MAX+1);
	localparam int LCW = $clog2(LOG_MAX+1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN   = 4'd1;
	localparam logic [3:0] S_DEC    = 4'd2;
	localparam logic [3:0] S_EALOOP = 4'd3;
	localparam logic [3:0] S_VRD    = 4'd4;
	localparam logic [3:0] S_VLOG   = 4'd5;
	localparam logic [3:0] S_INS    = 4'd6;
	localparam logic [3:0] S_FIND   = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	logic [3:0]          state_q;
	logic [CFG_W-1:0]    cap_q;
	logic [CFG_W-1:0]    depth_q;
	logic [OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                hit_q;
	logic [VALUE_BITS-1:0] vout_q;
	logic                rsn_q;
	logic                ev_q;
	logic [KEY_BITS-1:0] evkey_q;
	logic [ECNT_W-1:0]   ecnt_q;
	logic [IW-1:0]       hidx_q;
	logic [IW-1:0]       victim_q;
	logic [IW-1:0]       slot_q;
	logic [CW-1:0]       scnt_q;
	logic [LCW-1:0]      fcnt_q;
	logic                pend_s1;
	logic [IW-1:0]       addr_s1;
	logic                rsp_v_q;

	logic [CW-1:0]         effcap;
	age_cmd_t              age_cmd;
	logic [CAPACITY_MAX-1:0] valid;
	logic [CW-1:0]         live;
	logic [IW-1:0]         lru_idx;
	logic [IW-1:0]         free_idx;
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	logic [IW-1:0]         mem_raddr;
	logic [KEY_BITS-1:0]   erd_key;
	logic [VALUE_BITS-1:0] erd_val;
	logic [KEY_BITS-1:0]   lrd_key;
	logic [VALUE_BITS-1:0] lrd_val;
	logic                  lrd_reason;
	logic [LCW-1:0]        log_count;
	logic                  out_load;

	assign effcap = (cap_q == '0) ? CW'(1) :
		(32'(cap_q) > CAPACITY_MAX) ? CW'(CAPACITY_MAX) : CW'(cap_q);

	always_comb begin
		age_cmd = '{op: AGE_NOP, idx: '0};
		mem_we = 1'b0;
		mem_waddr = hidx_q;
		mem_raddr = victim_q;
		if (state_q == S_SCAN) mem_raddr = scnt_q[IW-1:0];
		if (state_q == S_DEC && hit_q) begin
			age_cmd = '{op: AGE_TOUCH, idx: IDX_MAX_W'(hidx_q)};
			mem_we = (op_q == OP_PUT) || (op_q == OP_EVICT);
		end
		if (state_q == S_VLOG) age_cmd = '{op: AGE_DROP, idx: IDX_MAX_W'(victim_q)};
		if (state_q == S_INS) begin
			age_cmd = '{op: AGE_INSERT, idx: IDX_MAX_W'(slot_q)};
			mem_we = 1'b1;
			mem_waddr = slot_q;
		end
	end

	lce_entry_mem #(.DEPTH(CAPACITY_MAX), .KB(KEY_BITS), .VB(VALUE_BITS)) u_mem (
		.clk(clk), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_key(key_q), .wr_val(val_q),
		.rd_addr(mem_raddr), .rd_key(erd_key), .rd_val(erd_val)
	);

	lce_age #(.DEPTH(CAPACITY_MAX)) u_age (
		.clk(clk), .arst_n(arst_n), .cmd(age_cmd), .valid(valid), .live(live),
		.lru_idx(lru_idx), .free_idx(free_idx)
	);

	lce_log #(.LOG_MAX(LOG_MAX), .KB(KEY_BITS), .VB(VALUE_BITS)) u_log (
		.clk(clk), .arst_n(arst_n), .depth(depth_q), .push_en(state_q == S_VLOG),
		.push_key(erd_key), .push_val(erd_val), .push_reason(op_q == OP_EVICT),
		.rd_n(fcnt_q), .rd_key(lrd_key), .rd_val(lrd_val), .rd_reason(lrd_reason),
		.count(log_count)
	);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign out_load  = (state_q == S_OUT) && (!rsp_v_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAPACITY_RESET;
			depth_q <= LOG_DEPTH_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				REG_CAPACITY:  cap_q <= cfg.data;
				REG_LOG_DEPTH: depth_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_PUT;
			key_q    <= '0;
			val_q    <= '0;
			hit_q    <= 1'b0;
			vout_q   <= '0;
			rsn_q    <= 1'b0;
			ev_q     <= 1'b0;
			evkey_q  <= '0;
			ecnt_q   <= '0;
			hidx_q   <= '0;
			victim_q <= '0;
			slot_q   <= '0;
			scnt_q   <= '0;
			fcnt_q   <= '0;
			pend_s1  <= 1'b0;
			addr_s1  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.op;
						key_q   <= req.key;
						val_q   <= req.value;
						hit_q   <= 1'b0;
						vout_q  <= '0;
						rsn_q   <= 1'b0;
						ev_q    <= 1'b0;
						evkey_q <= '0;
						ecnt_q  <= '0;
						scnt_q  <= '0;
						fcnt_q  <= '0;
						pend_s1 <= 1'b0;
						if (req.key == '0) state_q <= S_OUT;
						else if (req.op == OP_FIND) state_q <= S_FIND;
						else state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					pend_s1 <= (32'(scnt_q) < CAPACITY_MAX);
					addr_s1 <= scnt_q[IW-1:0];
					if (32'(scnt_q) < CAPACITY_MAX) scnt_q <= scnt_q + CW'(1);
					if (pend_s1 && valid[addr_s1] && erd_key == key_q) begin
						hit_q  <= 1'b1;
						hidx_q <= addr_s1;
						if (op_q == OP_GET) vout_q <= erd_val;
					end
					if (32'(scnt_q) >= CAPACITY_MAX && !pend_s1) state_q <= S_DEC;
				end
				S_DEC: begin
					if (op_q == OP_PUT && !hit_q) begin
						if (live >= effcap) begin
							victim_q <= lru_idx;
							state_q  <= S_VRD;
						end else begin
							slot_q  <= free_idx;
							state_q <= S_INS;
						end
					end else if (op_q == OP_EVICT && hit_q) begin
						state_q <= S_EALOOP;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_EALOOP: begin
					if (live > CW'(1)) begin
						victim_q <= lru_idx;
						state_q  <= S_VRD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_VRD: state_q <= S_VLOG;
				S_VLOG: begin
					if (op_q == OP_PUT) begin
						ev_q    <= 1'b1;
						evkey_q <= erd_key;
						slot_q  <= victim_q;
						state_q <= S_INS;
					end else begin
						ecnt_q  <= ecnt_q + ECNT_W'(1);
						state_q <= S_EALOOP;
					end
				end
				S_INS: state_q <= S_OUT;
				S_FIND: begin
					pend_s1 <= (fcnt_q < log_count);
					if (fcnt_q < log_count) fcnt_q <= fcnt_q + LCW'(1);
					if (pend_s1 && !hit_q && lrd_key == key_q) begin
						hit_q  <= 1'b1;
						vout_q <= lrd_val;
						rsn_q  <= lrd_reason;
					end
					if (fcnt_q >= log_count && !pend_s1) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (out_load) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.hit         <= hit_q;
			rsp.value_out   <= vout_q;
			rsp.reason_out  <= rsn_q;
			rsp.evicted     <= ev_q;
			rsp.evicted_key <= evkey_q;
			rsp.evict_count <= ecnt_q;
			rsp.size_out    <= SIZE_W'(live);
		end
	end

	assign rsp.valid = rsp_v_q;

	`LCE_ASSERT_NOW(a_live_matches_valid, 1'b1, $countones(valid) == 32'(live), "live count off")
	`LCE_ASSERT_NEXT(a_insert_grows, state_q == S_INS, live == $past(live) + CW'(1), "insert lost")
	`LCE_ASSERT_NEXT(a_drop_shrinks, state_q == S_VLOG, live == $past(live) - CW'(1), "drop lost")
	`LCE_ASSERT_NOW(a_log_bound, 1'b1, 32'(log_count) <= LOG_MAX, "log overfull")
endmodule
